// ===== rtl/dsat_pkg.sv =====
// dsat_pkg: shared sizes, opcodes, beat structs and state type for the slot table
`timescale 1ns / 1ps

package dsat_pkg;

    // table sizing
    localparam int SLOT_COUNT = 16;
    localparam int KEY_WIDTH  = 64;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    // common width for comparing and resizing slot numbers and counts
    localparam int CMP_W      = 8;

    // command opcodes
    localparam logic [1:0] OP_RESOLVE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_BEGIN   = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // command beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] profile_key;
        logic        is_leaf;
        logic [3:0]  slot_index;
    } t_dsat_cmd;

    // result beat
    typedef struct packed {
        logic        slot_found;
        logic [3:0]  slot_number;
        logic [63:0] read_key;
        logic [4:0]  assigned_count;
        logic [31:0] overflow_count;
    } t_dsat_res;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_dsat_state;

    // slot number resized to the result field
    function automatic logic [3:0] slot_to_field(input logic [SLOT_W-1:0] slot);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(slot);
        return wide[3:0];
    endfunction

    // slot count resized to the result field
    function automatic logic [4:0] count_to_field(input logic [CNT_W-1:0] cnt);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(cnt);
        return wide[4:0];
    endfunction

endpackage

// ===== rtl/dsat_key_ram.sv =====
// dsat_key_ram: key store, one write port and one registered read port
`timescale 1ns / 1ps

module dsat_key_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/dedup_slot_allocation_table_core.sv =====
// dedup_slot_allocation_table_core: top level of the deduplicating slot table
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------
//  command   | start, busy           | i_cmd  (t_dsat_cmd)
//  result    | o_done (1-cycle strobe)| o_res (t_dsat_res)
//
//  a command beat is taken when start is high and busy is low
//  resolve of a leaf key scans the assigned slots through the key ram, one read
//  per cycle, and ends at the first matching slot or after the last assigned one
//  read of an assigned slot passes through the registered ram read, all other commands answer from idle
//  synchronous active-low reset empties the table and clears the refusal count;
//  clear all needs no sweep, slots past the assigned count always read as zero
//  results cannot be held off; a new command may be taken during the strobe cycle
`timescale 1ns / 1ps

module dedup_slot_allocation_table_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  dsat_pkg::t_dsat_cmd i_cmd,
    output logic                o_done,
    output dsat_pkg::t_dsat_res o_res
);

    import dsat_pkg::*;

    // control and counters
    t_dsat_state          r_state, n_state;
    logic [CNT_W-1:0]     r_next_free, n_next_free;
    logic [31:0]          r_refused, n_refused;
    logic                 r_done, n_done;

    // scan bookkeeping
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]    r_cmp_idx, n_cmp_idx;

    // latched command and result payload
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_found, n_found;
    logic [3:0]           r_slot, n_slot;
    logic [63:0]          r_rkey, n_rkey;

    // ram ports
    logic                 ram_wr_en;
    logic [SLOT_W-1:0]    ram_wr_addr;
    logic                 ram_rd_en;
    logic [SLOT_W-1:0]    ram_rd_addr;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    // decode helpers
    logic                 accept;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     free_ext;
    logic [CMP_W-1:0]     addr_ext;
    logic                 idx_ok;
    logic                 scan_more;
    logic                 hit;
    logic                 full;

    assign accept    = start && (r_state == ST_IDLE);
    assign idx_ext   = CMP_W'(i_cmd.slot_index);
    assign free_ext  = CMP_W'(r_next_free);
    assign addr_ext  = CMP_W'(r_addr);
    assign idx_ok    = idx_ext < free_ext;
    assign scan_more = addr_ext < free_ext;
    assign hit       = r_cmp_vld && (ram_rd_data == r_key);
    assign full      = (free_ext == CMP_W'(SLOT_COUNT));

    dsat_key_ram #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (KEY_WIDTH),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.opcode == OP_RESOLVE && i_cmd.is_leaf) begin
                        n_state = ST_SCAN;
                    end else if (i_cmd.opcode == OP_READ && idx_ok) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || !scan_more) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_next_free = r_next_free;
        n_refused   = r_refused;
        n_done      = 1'b0;
        n_addr      = r_addr;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_key       = r_key;
        n_found     = r_found;
        n_slot      = r_slot;
        n_rkey      = r_rkey;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_next_free[SLOT_W-1:0];
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_addr[SLOT_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_key     = i_cmd.profile_key[KEY_WIDTH-1:0];
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                    n_slot    = '0;
                    n_rkey    = '0;
                    unique case (i_cmd.opcode)
                        OP_RESOLVE: begin
                            n_done = !i_cmd.is_leaf;
                        end
                        OP_READ: begin
                            ram_rd_addr = idx_ext[SLOT_W-1:0];
                            ram_rd_en   = idx_ok;
                            n_done      = !idx_ok;
                        end
                        OP_BEGIN: begin
                            n_next_free = '0;
                            n_done      = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_next_free = '0;
                            n_refused   = '0;
                            n_done      = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next slot read while comparing the previous one
                ram_rd_en = scan_more;
                n_cmp_vld = scan_more;
                n_cmp_idx = r_addr[SLOT_W-1:0];
                if (scan_more) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_slot  = slot_to_field(r_cmp_idx);
                    n_done  = 1'b1;
                end else if (!scan_more) begin
                    n_done = 1'b1;
                    if (full) begin
                        if (r_refused != '1) begin
                            n_refused = r_refused + 32'd1;
                        end
                    end else begin
                        // no match: take the next free slot
                        ram_wr_en   = 1'b1;
                        n_next_free = r_next_free + CNT_W'(1);
                        n_found     = 1'b1;
                        n_slot      = slot_to_field(r_next_free[SLOT_W-1:0]);
                    end
                end
            end
            ST_READ: begin
                n_rkey = 64'(ram_rd_data);
                n_done = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_free <= '0;
            r_refused   <= '0;
            r_done      <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_refused   <= n_refused;
            r_done      <= n_done;
            r_cmp_vld   <= n_cmp_vld;
            r_addr      <= n_addr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_found   <= n_found;
        r_slot    <= n_slot;
        r_rkey    <= n_rkey;
    end

    // result beat
    assign busy                 = (r_state != ST_IDLE);
    assign o_done               = r_done;
    assign o_res.slot_found     = r_found;
    assign o_res.slot_number    = r_slot;
    assign o_res.read_key       = r_rkey;
    assign o_res.assigned_count = count_to_field(r_next_free);
    assign o_res.overflow_count = r_refused;

endmodule

// ===== rtl/dsat_checker.sv =====
// dsat_checker: port-level assertions for the slot table, bound to the top level
`timescale 1ns / 1ps

module dsat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input dsat_pkg::t_dsat_cmd i_cmd,
    input logic                o_done,
    input dsat_pkg::t_dsat_res o_res
);

    import dsat_pkg::*;

    // frame commands report an empty table on the next cycle
    a_frame_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_BEGIN || i_cmd.opcode == OP_CLEAR))
        |=> (o_done && o_res.assigned_count == 5'd0))
        else $error("frame command did not report an empty table");

    // clear all zeroes the refusal count
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == OP_CLEAR) |=> (o_res.overflow_count == 32'd0))
        else $error("clear all left a refusal count");

    // a result beat always comes with the command side free
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // no slot found means slot number zero
    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_res.slot_found) |-> (o_res.slot_number == 4'd0))
        else $error("slot number set without a slot");

    // assigned count never exceeds the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_res.assigned_count) <= 32'(SLOT_COUNT)))
        else $error("assigned count beyond table size");

endmodule

bind dedup_slot_allocation_table_core dsat_checker u_dsat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ===== bench/tb_dedup_slot_allocation_table_core.sv =====
// tb_dedup_slot_allocation_table_core: self-checking bench for the dedup slot table core
`timescale 1ns / 1ps

module tb_dedup_slot_allocation_table_core;

    import dsat_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RAND_PER_PHASE = 433;
    localparam int POOL_SIZE      = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_done;
    t_dsat_cmd i_cmd;
    t_dsat_res o_res;

    // one row of the directed stimulus, with an optional hand-typed result
    typedef struct {
        t_dsat_cmd cmd;
        bit        typed;
        t_dsat_res res;
    } t_dir_row;

    t_dir_row             dir_rows[$];
    t_dsat_res            slot_results_due[$];
    logic [KEY_WIDTH-1:0] shadow_keys [SLOT_COUNT];
    int unsigned          shadow_fill;
    logic [31:0]          shadow_refusals;
    logic [63:0]          key_pool [POOL_SIZE];
    int                   err_count;
    int                   quiet_cycles;
    int                   idle_pct;

    dedup_slot_allocation_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // shadow copy of the table: works out the result beat of one command
    function automatic t_dsat_res slot_table_outcome(input t_dsat_cmd c);
        t_dsat_res            r;
        logic [KEY_WIDTH-1:0] k;
        bit                   hit;
        r   = '0;
        k   = c.profile_key[KEY_WIDTH-1:0];
        hit = 1'b0;
        case (c.opcode)
            OP_RESOLVE: begin
                if (c.is_leaf) begin
                    // lowest matching slot of this frame wins
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (!hit && s < shadow_fill && shadow_keys[s] == k) begin
                            hit           = 1'b1;
                            r.slot_found  = 1'b1;
                            r.slot_number = 4'(s);
                        end
                    end
                    if (!hit) begin
                        if (shadow_fill >= SLOT_COUNT) begin
                            // table full: refused, counter saturates
                            if (shadow_refusals != '1) begin
                                shadow_refusals++;
                            end
                        end else begin
                            shadow_keys[shadow_fill] = k;
                            r.slot_found             = 1'b1;
                            r.slot_number            = 4'(shadow_fill);
                            shadow_fill++;
                        end
                    end
                end
            end
            OP_READ: begin
                // stale keys past the fill level read as zero
                if (c.slot_index < SLOT_COUNT && c.slot_index < shadow_fill) begin
                    r.read_key = 64'(shadow_keys[c.slot_index]);
                end
            end
            OP_BEGIN: begin
                shadow_fill = 0;
            end
            default: begin
                shadow_fill     = 0;
                shadow_refusals = '0;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    shadow_keys[s] = '0;
                end
            end
        endcase
        r.assigned_count = 5'(shadow_fill);
        r.overflow_count = shadow_refusals;
        return r;
    endfunction

    // append one directed row
    function automatic void add_row(input logic [1:0] op, input logic [63:0] key,
                                    input logic leaf, input logic [3:0] idx, input bit typed,
                                    input logic found, input logic [3:0] slot,
                                    input logic [63:0] rkey, input logic [4:0] cnt,
                                    input logic [31:0] ovf);
        t_dir_row row;
        row.cmd.opcode          = op;
        row.cmd.profile_key     = key;
        row.cmd.is_leaf         = leaf;
        row.cmd.slot_index      = idx;
        row.typed               = typed;
        row.res.slot_found      = found;
        row.res.slot_number     = slot;
        row.res.read_key        = rkey;
        row.res.assigned_count  = cnt;
        row.res.overflow_count  = ovf;
        dir_rows.push_back(row);
    endfunction

    // field-by-field compare of one result beat
    task automatic check_beat(input t_dsat_res exp_res, input t_dsat_res act);
        if (act.slot_found !== exp_res.slot_found) begin
            $display("%0t: slot_found expected %0h actual %0h",
                     $time, exp_res.slot_found, act.slot_found);
            err_count++;
        end
        if (act.slot_number !== exp_res.slot_number) begin
            $display("%0t: slot_number expected %0d actual %0d",
                     $time, exp_res.slot_number, act.slot_number);
            err_count++;
        end
        if (act.read_key !== exp_res.read_key) begin
            $display("%0t: read_key expected %016h actual %016h",
                     $time, exp_res.read_key, act.read_key);
            err_count++;
        end
        if (act.assigned_count !== exp_res.assigned_count) begin
            $display("%0t: assigned_count expected %0d actual %0d",
                     $time, exp_res.assigned_count, act.assigned_count);
            err_count++;
        end
        if (act.overflow_count !== exp_res.overflow_count) begin
            $display("%0t: overflow_count expected %0d actual %0d",
                     $time, exp_res.overflow_count, act.overflow_count);
            err_count++;
        end
    endtask

    // present one command beat, hold it until taken, then queue its result
    task automatic offer_beat(input t_dsat_cmd c, input bit typed, input t_dsat_res typed_res);
        t_dsat_res predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = slot_table_outcome(c);
        slot_results_due.push_back(typed ? typed_res : predicted);
    endtask

    // hold off until every queued result beat has come back
    task automatic drain_results();
        start <= 1'b0;
        while (slot_results_due.size() != 0) @(posedge i_clk);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (slot_results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %p", $time, o_res);
                err_count++;
            end else begin
                check_beat(slot_results_due.pop_front(), o_res);
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dedup_slot_allocation_table_core: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_dsat_cmd c;
        t_dsat_res none;
        int        roll;
        start           = 1'b0;
        i_cmd           = '0;
        i_rst_n         = 1'b0;
        err_count       = 0;
        quiet_cycles    = 0;
        idle_pct        = 0;
        none            = '0;
        shadow_fill     = 0;
        shadow_refusals = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            shadow_keys[s] = '0;
        end
        // key pool: extremes plus random keys, reused to force matches
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int p = 2; p < POOL_SIZE; p++) begin
            key_pool[p] = {$urandom, $urandom};
        end

        // directed rows: empty read, non-leaf, first slots, match, fill, full, frames
        add_row(OP_READ, 64'hdead_beef_cafe_f00d, 1'b1, 4'd0, 1'b1,
                1'b0, 4'd0, 64'd0, 5'd0, 32'd0);
        add_row(OP_RESOLVE, '1, 1'b0, 4'd15, 1'b1, 1'b0, 4'd0, 64'd0, 5'd0, 32'd0);
        add_row(OP_RESOLVE, '0, 1'b1, 4'd0, 1'b1, 1'b1, 4'd0, 64'd0, 5'd1, 32'd0);
        add_row(OP_RESOLVE, '1, 1'b1, 4'd0, 1'b1, 1'b1, 4'd1, 64'd0, 5'd2, 32'd0);
        add_row(OP_RESOLVE, '0, 1'b1, 4'd7, 1'b1, 1'b1, 4'd0, 64'd0, 5'd2, 32'd0);
        add_row(OP_READ, 64'd0, 1'b0, 4'd1, 1'b1, 1'b0, 4'd0, '1, 5'd2, 32'd0);
        for (int n = 2; n < SLOT_COUNT; n++) begin
            add_row(OP_RESOLVE, {8'ha5, 8'(n), 16'($urandom), $urandom}, 1'b1, 4'(n),
                    1'b0, 1'b0, 4'd0, 64'd0, 5'd0, 32'd0);
        end
        add_row(OP_RESOLVE, 64'h0123_4567_89ab_cdef, 1'b1, 4'd0, 1'b1,
                1'b0, 4'd0, 64'd0, 5'(SLOT_COUNT), 32'd1);
        add_row(OP_RESOLVE, '1, 1'b1, 4'd0, 1'b1, 1'b1, 4'd1, 64'd0, 5'(SLOT_COUNT), 32'd1);
        add_row(OP_BEGIN, '1, 1'b1, 4'd15, 1'b1, 1'b0, 4'd0, 64'd0, 5'd0, 32'd1);
        add_row(OP_READ, 64'd0, 1'b1, 4'd1, 1'b1, 1'b0, 4'd0, 64'd0, 5'd0, 32'd1);
        add_row(OP_CLEAR, '1, 1'b1, 4'd15, 1'b1, 1'b0, 4'd0, 64'd0, 5'd0, 32'd0);

        // reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, back to back
        foreach (dir_rows[n]) begin
            offer_beat(dir_rows[n].cmd, dir_rows[n].typed, dir_rows[n].res);
        end
        drain_results();

        // random part: no idling, heavy sender idling, light sender idling
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 56 : 24;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                roll          = $urandom_range(0, 99);
                c.profile_key = {$urandom, $urandom};
                c.is_leaf     = 1'($urandom_range(0, 1));
                c.slot_index  = 4'($urandom_range(0, 15));
                if (roll < 62) begin
                    // mostly leaf keys, often repeats from the pool
                    c.opcode  = OP_RESOLVE;
                    c.is_leaf = ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 99) < 60) begin
                        c.profile_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    end
                end else if (roll < 96) begin
                    c.opcode = OP_READ;
                end else if (roll < 99) begin
                    c.opcode = OP_BEGIN;
                end else begin
                    c.opcode = OP_CLEAR;
                end
                // let the pool drift slowly
                if ($urandom_range(0, 49) == 0) begin
                    key_pool[$urandom_range(2, POOL_SIZE - 1)] = {$urandom, $urandom};
                end
                offer_beat(c, 1'b0, none);
            end
            drain_results();
        end

        // tail: catch stray beats
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (slot_results_due.size() != 0) begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, slot_results_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("tb_dedup_slot_allocation_table_core: done, clean");
        end else begin
            $display("tb_dedup_slot_allocation_table_core: done, errors");
        end
        $finish;
    end

endmodule
